/* hw/rtl/assert_macros.svh */
// Assertion helpers used by the handshake checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/tsmb_pkg.sv */
package tsmb_pkg;

  localparam int unsigned ACC_W = 50;
  localparam logic [2:0] FLAGS_ALL = 3'b111;
  localparam logic signed [31:0] Q_ONE = 32'sd65536;
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam logic [6:0] ANGLE_DIV = 7'd45;

  typedef struct packed {
    logic              op;
    logic [2:0]        srt_flags;
    logic signed [31:0] scale_u;
    logic signed [31:0] scale_v;
    logic signed [31:0] rot_degrees;
    logic signed [31:0] trans_u;
    logic signed [31:0] trans_v;
  } in_item_t;

  typedef struct packed {
    logic              applied;
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m03;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m13;
  } out_item_t;

  typedef enum logic [2:0] {
    OA_SU, OA_SV, OA_SUCR, OA_SUSR, OA_SVCR, OA_SVSR
  } opa_t;

  typedef enum logic [2:0] {
    OB_C, OB_S, OB_TU, OB_TV, OB_MLO, OB_MHI, OB_A, OB_B
  } opb_t;

  typedef enum logic [1:0] {
    IN_ZERO, IN_CONT, IN_SUSR, IN_ONE_SVCR
  } acc_init_t;

  typedef enum logic [3:0] {
    DS_NONE, DS_SUCR, DS_SUSR, DS_SVCR, DS_SVSR, DS_TMP, DS_PAIR, DS_BUILD,
    DS_M03, DS_M13
  } dest_t;

  typedef struct packed {
    opa_t      opa;
    opb_t      opb;
    acc_init_t init;
    logic      neg;
    dest_t     dest;
  } uop_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) r = 32'sh7fffffff;
    else if (v < -50'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] ext32(input logic signed [31:0] v);
    return {{(ACC_W-32){v[31]}}, v};
  endfunction

  // Quarter-wave sample k of a table with 2^bits points per turn, unsigned Q1.16.
  // Each series term is divided by (2n)(2n+1) through a ceil(2^64 / d) reciprocal.
  function automatic logic [16:0] wave_point(input int unsigned bits, input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned rc;
    logic [127:0]    wide;
    longint sum;
    longint r;
    x = (PI_Q30 * 64'd2 * 64'(k)) >> bits;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      case (n)
        1: rc = 64'd3074457345618258603;
        2: rc = 64'd922337203685477581;
        3: rc = 64'd439208192231179801;
        4: rc = 64'd256204778801521551;
        5: rc = 64'd167697673397359561;
        6: rc = 64'd118248359446856101;
        default: rc = 64'd87841638446235961;
      endcase
      wide = 128'((term * x2) >> 30) * 128'(rc);
      term = wide[127:64];
      if (n[0]) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (sum + 64'sd8192) >>> 14;
    if (r > 64'sd65536) r = 64'sd65536;
    return r[16:0];
  endfunction

endpackage

/* hw/rtl/tsmb_if.sv */
interface tsmb_in_if;
  import tsmb_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface tsmb_out_if;
  import tsmb_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

/* hw/rtl/texture_srt_matrix_builder.sv */
// Channel  Dir  Handshake      Payload
// in_ch    in   valid/ready    op, srt_flags, scale_u/v, rot_degrees, trans_u/v
// out_ch   out  valid/ready    applied, m00..m03, m10..m13
//
// With all flags set the item goes straight to the result; otherwise an item whose
// angle is used first takes the angle-to-index reciprocal multiply on the shared
// multiplier, then a build issues 8 products and a multiply 20, one product a cycle
// on the shared 32x32 multiplier. Reset loads the identity rows, no sweep.
// in_ch.ready is high only while idle; a waiting result does not block the next
// item, but the next result waits for out_ch to drain.
module texture_srt_matrix_builder #(
  parameter int SINE_TABLE_BITS = 8
) (
  input logic clk,
  input logic rst_n,
  tsmb_in_if.sink in_ch,
  tsmb_out_if.source out_ch
);
  import tsmb_pkg::*;

  localparam int TB = SINE_TABLE_BITS;
  localparam int NPTS = 1 << TB;
  localparam int QUARTER = NPTS / 4;
  localparam int QIW = TB - 1;
  localparam int DW = TB + 14;
  localparam int NW = TB + 33;
  localparam int DIV_SH = DW + 6;
  localparam logic [DW-1:0] DIV_OFS = DW'(5760 * NPTS);
  localparam logic signed [NW-1:0] HALF_TURN = NW'(180 * 65536);
  localparam longint unsigned RECIP =
    ((64'd1 << DIV_SH) + 64'(ANGLE_DIV) - 64'd1) / 64'(ANGLE_DIV);
  localparam logic signed [31:0] RECIP_Q = 32'(RECIP);

  typedef logic [16:0] wave_tab_t [QUARTER+1];

  function automatic wave_tab_t build_wave();
    wave_tab_t w;
    for (int k = 0; k <= QUARTER; k++) w[k] = wave_point(TB, k);
    return w;
  endfunction

  localparam wave_tab_t WAVE = build_wave();

  function automatic logic signed [17:0] wave_sin(input logic [TB-1:0] idx);
    logic [1:0] quad;
    logic [QIW-1:0] r;
    logic [QIW-1:0] rr;
    logic signed [17:0] v;
    quad = idx[TB-1:TB-2];
    r = QIW'(idx[TB-3:0]);
    rr = QIW'(QUARTER) - r;
    case (quad)
      2'd0: v = signed'({1'b0, WAVE[r]});
      2'd1: v = signed'({1'b0, WAVE[rr]});
      2'd2: v = -signed'({1'b0, WAVE[r]});
      default: v = -signed'({1'b0, WAVE[rr]});
    endcase
    return v;
  endfunction

  function automatic uop_t decode(input logic mode, input logic [4:0] u);
    uop_t d;
    d = '{opa: OA_SU, opb: OB_C, init: IN_ZERO, neg: 1'b0, dest: DS_NONE};
    if (u < 5'd4) begin
      case (u[1:0])
        2'd0: d = '{OA_SU, OB_C, IN_ZERO, 1'b0, DS_SUCR};
        2'd1: d = '{OA_SU, OB_S, IN_ZERO, 1'b0, DS_SUSR};
        2'd2: d = '{OA_SV, OB_C, IN_ZERO, 1'b0, DS_SVCR};
        default: d = '{OA_SV, OB_S, IN_ZERO, 1'b0, DS_SVSR};
      endcase
    end else if (!mode) begin
      case (u[1:0])
        2'd0: d = '{OA_SUCR, OB_TU, IN_SUSR, 1'b1, DS_NONE};
        2'd1: d = '{OA_SUSR, OB_TV, IN_CONT, 1'b1, DS_BUILD};
        2'd2: d = '{OA_SVSR, OB_TU, IN_ONE_SVCR, 1'b1, DS_NONE};
        default: d = '{OA_SVCR, OB_TV, IN_CONT, 1'b0, DS_M13};
      endcase
    end else if (u >= 5'd16) begin
      case (u[1:0])
        2'd0: d = '{OA_SUCR, OB_A, IN_SUSR, 1'b0, DS_NONE};
        2'd1: d = '{OA_SUSR, OB_B, IN_CONT, 1'b1, DS_M03};
        2'd2: d = '{OA_SVSR, OB_A, IN_ONE_SVCR, 1'b0, DS_NONE};
        default: d = '{OA_SVCR, OB_B, IN_CONT, 1'b0, DS_M13};
      endcase
    end else begin
      case (u[1:0])
        2'd0: d = '{OA_SUCR, OB_MLO, IN_ZERO, 1'b0, DS_NONE};
        2'd1: d = '{OA_SUSR, OB_MHI, IN_CONT, 1'b1, DS_TMP};
        2'd2: d = '{OA_SVSR, OB_MLO, IN_ZERO, 1'b0, DS_NONE};
        default: d = '{OA_SVCR, OB_MHI, IN_CONT, 1'b0, DS_PAIR};
      endcase
    end
    return d;
  endfunction

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_TRIG  = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic               op_r, applied_r, rot0_r;
  logic signed [31:0] su_r, sv_r, tu_r, tv_r;
  logic signed [17:0] s_r, c_r;
  logic signed [31:0] sucr_r, susr_r, svcr_r, svsr_r, tmp_r, a_r, b_r;
  logic signed [31:0] m00_r, m01_r, m02_r, m03_r, m10_r, m11_r, m12_r, m13_r;
  logic [DW-1:0]      dvd_r;
  logic [4:0]         u_r;
  logic signed [63:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;
  uop_t               st_r;
  logic               st_v_r;
  logic [1:0]         st_lane_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic               in_acc;
  logic signed [NW-1:0] ang_num;
  logic [DW-1:0]      dvd_in;
  uop_t               cur;
  logic [1:0]         lane;
  logic signed [31:0] opa, opb, mlo, mhi;
  logic signed [31:0] mul_a, mul_b;
  logic [4:0]         u_last;
  logic signed [63:0] rnd_sum;
  logic signed [ACC_W-1:0] base, pq, acc_sum;
  logic signed [31:0] res;
  logic [TB-1:0]      idx;
  logic               out_free;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.item = out_r;
  assign out_free = !out_valid_r || out_ch.ready;

  // Angle index: floor(floor((deg * N + 180 * 2^16) / 2^19) / 45); offset keeps it
  // positive, divide by 45 through a reciprocal multiply on the shared multiplier.
  assign ang_num = ({{(NW-32){in_ch.item.rot_degrees[31]}}, in_ch.item.rot_degrees} <<< TB)
                   + HALF_TURN;
  assign dvd_in = ang_num[NW-1:19] + DIV_OFS;

  assign idx = prod_r[DIV_SH +: TB];

  assign cur = decode(op_r, u_r);
  assign lane = u_r[3:2] - 2'd1;
  assign u_last = op_r ? 5'd19 : 5'd7;

  assign mul_a = (state_r == ST_DIV) ? signed'(32'(dvd_r)) : opa;
  assign mul_b = (state_r == ST_DIV) ? RECIP_Q : opb;

  always_comb begin
    case (lane)
      2'd0: begin mlo = m00_r; mhi = m10_r; end
      2'd1: begin mlo = m01_r; mhi = m11_r; end
      default: begin mlo = m02_r; mhi = m12_r; end
    endcase
    case (cur.opa)
      OA_SU:   opa = su_r;
      OA_SV:   opa = sv_r;
      OA_SUCR: opa = sucr_r;
      OA_SUSR: opa = susr_r;
      OA_SVCR: opa = svcr_r;
      OA_SVSR: opa = svsr_r;
      default: opa = su_r;
    endcase
    case (cur.opb)
      OB_C:   opb = 32'(c_r);
      OB_S:   opb = 32'(s_r);
      OB_TU:  opb = tu_r;
      OB_TV:  opb = tv_r;
      OB_MLO: opb = mlo;
      OB_MHI: opb = mhi;
      OB_A:   opb = a_r;
      default: opb = b_r;
    endcase
  end

  // Round half up, then add to or subtract from the selected base (zero, the running sum or a preset).
  always_comb begin
    rnd_sum = prod_r + 64'sd32768;
    pq = ACC_W'(signed'(rnd_sum[63:16]));
    case (st_r.init)
      IN_ZERO:     base = '0;
      IN_CONT:     base = acc_r;
      IN_SUSR:     base = ext32(susr_r);
      default:     base = ext32(Q_ONE) - ext32(svcr_r);
    endcase
    acc_sum = st_r.neg ? base - pq : base + pq;
    res = sat32(acc_sum);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.item.srt_flags == FLAGS_ALL) state_nxt = ST_FIN;
          else if (in_ch.item.srt_flags[1]) state_nxt = ST_TRIG;
          else state_nxt = ST_DIV;
        end
      end
      ST_DIV:   state_nxt = ST_TRIG;
      ST_TRIG:  state_nxt = ST_MUL;
      ST_MUL:   if (u_r == u_last) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_FIN;
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      st_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      st_v_r <= (state_r == ST_MUL);
      if (state_r == ST_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // Item capture, angle index, table lookup and multiplier issue.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_r <= in_ch.item.op;
          applied_r <= (in_ch.item.srt_flags != FLAGS_ALL);
          rot0_r <= in_ch.item.srt_flags[1];
          su_r <= in_ch.item.srt_flags[0] ? Q_ONE : in_ch.item.scale_u;
          sv_r <= in_ch.item.srt_flags[0] ? Q_ONE : in_ch.item.scale_v;
          tu_r <= in_ch.item.srt_flags[2] ? 32'sd0 : in_ch.item.trans_u;
          tv_r <= in_ch.item.srt_flags[2] ? 32'sd0 : in_ch.item.trans_v;
          s_r <= 18'sd0;
          c_r <= 18'(Q_ONE);
          dvd_r <= dvd_in;
          u_r <= '0;
        end
      end
      ST_DIV: begin
        prod_r <= mul_a * mul_b;
      end
      ST_TRIG: begin
        if (!rot0_r) begin
          s_r <= wave_sin(idx);
          c_r <= wave_sin(idx + TB'(QUARTER));
        end
        a_r <= sat32(ext32(m03_r) - ext32(tu_r));
        b_r <= sat32(ext32(m13_r) + ext32(tv_r));
      end
      ST_MUL: begin
        prod_r <= mul_a * mul_b;
        st_r <= cur;
        st_lane_r <= lane;
        u_r <= u_r + 5'd1;
      end
      default: ;
    endcase
  end

  // Accumulate stage: write back the saturated result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m00_r <= Q_ONE; m01_r <= '0; m02_r <= '0; m03_r <= '0;
      m10_r <= '0; m11_r <= Q_ONE; m12_r <= '0; m13_r <= '0;
    end else if (st_v_r) begin
      case (st_r.dest)
        DS_BUILD: begin
          m00_r <= sucr_r;
          m01_r <= sat32(-ext32(susr_r));
          m02_r <= '0;
          m03_r <= res;
          m10_r <= svsr_r;
          m11_r <= svcr_r;
          m12_r <= '0;
        end
        DS_PAIR: begin
          case (st_lane_r)
            2'd0: begin m00_r <= tmp_r; m10_r <= res; end
            2'd1: begin m01_r <= tmp_r; m11_r <= res; end
            default: begin m02_r <= tmp_r; m12_r <= res; end
          endcase
        end
        DS_M03: m03_r <= res;
        DS_M13: m13_r <= res;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_v_r) begin
      acc_r <= acc_sum;
      case (st_r.dest)
        DS_SUCR: sucr_r <= res;
        DS_SUSR: susr_r <= res;
        DS_SVCR: svcr_r <= res;
        DS_SVSR: svsr_r <= res;
        DS_TMP:  tmp_r <= res;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && out_free) begin
      out_r <= '{applied: applied_r, m00: m00_r, m01: m01_r, m02: m02_r, m03: m03_r,
                 m10: m10_r, m11: m11_r, m12: m12_r, m13: m13_r};
    end
  end

endmodule

/* hw/rtl/tsmb_checker.sv */
`include "assert_macros.svh"

module tsmb_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  logic       in_hs, out_hs;
  logic [1:0] pend_r;

  assign in_hs = in_valid && in_ready;
  assign out_hs = out_valid && out_ready;

  // Items accepted and not yet delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= 2'd0;
    else pend_r <= pend_r + {1'b0, in_hs} - {1'b0, out_hs};
  end

  `CHK_SAME(a_no_extra_result, out_hs, pend_r != 2'd0, "result without a pending item")
  `CHK_NEXT(a_busy_after_accept, in_hs, !in_ready, "ready right after an accept")
  `CHK_SAME(a_two_in_flight, pend_r == 2'd2, !in_ready, "third item taken while two pending")
  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

endmodule

bind texture_srt_matrix_builder tsmb_checker u_tsmb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);

/* tb/srt_checker.sv */
module srt_checker #(
  parameter int SINE_TABLE_BITS = 8
) (
  input  logic clk,
  input  logic rst_n,
  tsmb_in_if   in_ch,
  tsmb_out_if  out_ch,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tsmb_pkg::*;

  localparam int TURN = 1 << SINE_TABLE_BITS;
  localparam int QUART = TURN / 4;
  localparam longint ONE = 65536;

  longint    sine_quarter[QUART+1];
  longint    mat[8];
  out_item_t matrix_q[$];

  function automatic longint floor_div(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q16.16 product, round half up, no saturation
  function automatic longint fx_mul(longint a, longint b);
    return floor_div(a * b + 32768, 65536);
  endfunction

  function automatic longint table_sin(longint idx);
    longint i, quad, r;
    i = idx & (TURN - 1);
    quad = i >> (SINE_TABLE_BITS - 2);
    r = i & (QUART - 1);
    case (quad)
      0: return sine_quarter[r];
      1: return sine_quarter[QUART - r];
      2: return -sine_quarter[r];
      default: return -sine_quarter[QUART - r];
    endcase
  endfunction

  initial begin
    longint unsigned x, x2, term;
    longint sum;
    for (int k = 0; k <= QUART; k++) begin
      x = 64'd3373259426 * 64'd2 * longint'(k) / longint'(TURN);
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      sum = (sum + 8192) / 16384;
      if (sum > ONE) sum = ONE;
      sine_quarter[k] = sum;
    end
  end

  function automatic out_item_t apply_srt(in_item_t it);
    out_item_t res;
    longint su, sv, tu, tv, s, c, idx, sucr, susr, svcr, svsr, r0, r1, a, b;
    res.applied = 1'b0;
    if (it.srt_flags != FLAGS_ALL) begin
      res.applied = 1'b1;
      su = it.srt_flags[0] ? ONE : longint'(it.scale_u);
      sv = it.srt_flags[0] ? ONE : longint'(it.scale_v);
      if (it.srt_flags[1]) begin
        s = 0;
        c = ONE;
      end else begin
        idx = floor_div(longint'(it.rot_degrees) * TURN + 360 * 32768, 360 * 65536);
        s = table_sin(idx);
        c = table_sin(idx + QUART);
      end
      tu = it.srt_flags[2] ? 0 : longint'(it.trans_u);
      tv = it.srt_flags[2] ? 0 : longint'(it.trans_v);
      sucr = clamp32(fx_mul(su, c));
      susr = clamp32(fx_mul(su, s));
      svcr = clamp32(fx_mul(sv, c));
      svsr = clamp32(fx_mul(sv, s));
      if (!it.op) begin
        mat[0] = sucr;
        mat[1] = clamp32(-susr);
        mat[2] = 0;
        mat[3] = clamp32(susr - fx_mul(sucr, tu) - fx_mul(susr, tv));
        mat[4] = svsr;
        mat[5] = svcr;
        mat[6] = 0;
        mat[7] = clamp32(-svcr - fx_mul(svsr, tu) + fx_mul(svcr, tv) + ONE);
      end else begin
        for (int i = 0; i < 3; i++) begin
          r0 = clamp32(fx_mul(sucr, mat[i]) - fx_mul(susr, mat[4+i]));
          r1 = clamp32(fx_mul(svsr, mat[i]) + fx_mul(svcr, mat[4+i]));
          mat[i] = r0;
          mat[4+i] = r1;
        end
        a = clamp32(mat[3] - tu);
        b = clamp32(mat[7] + tv);
        mat[3] = clamp32(fx_mul(sucr, a) - fx_mul(susr, b) + susr);
        mat[7] = clamp32(fx_mul(svsr, a) + fx_mul(svcr, b) - svcr + ONE);
      end
    end
    res.m00 = mat[0][31:0]; res.m01 = mat[1][31:0];
    res.m02 = mat[2][31:0]; res.m03 = mat[3][31:0];
    res.m10 = mat[4][31:0]; res.m11 = mat[5][31:0];
    res.m12 = mat[6][31:0]; res.m13 = mat[7][31:0];
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    int        errs;
    errs = 0;
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) mat[i] = 0;
      mat[0] = ONE;
      mat[5] = ONE;
      matrix_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      // pop first: a result leaving now belongs to an earlier item
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.item;
        if (matrix_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          errs++;
        end else begin
          want = matrix_q.pop_front();
          if (want.applied !== got.applied) begin
            $display("%0t: applied mismatch, expected %b, actual %b",
                     $time, want.applied, got.applied);
            errs++;
          end
          for (int i = 0; i < 8; i++)
            if (want[255-32*i -: 32] !== got[255-32*i -: 32]) begin
              $display("%0t: m%0d%0d mismatch, expected %h, actual %h", $time,
                       i / 4, i % 4, want[255-32*i -: 32], got[255-32*i -: 32]);
              errs++;
            end
        end
      end
      if (in_ch.valid && in_ch.ready) matrix_q.push_back(apply_srt(in_ch.item));
      fail_count <= fail_count + errs;
      pending <= matrix_q.size();
    end
  end
endmodule

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tsmb_pkg::*;

  localparam int TABLE_BITS = 8;
  localparam int RANDOM_ITEMS = 800;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  bit   hold_req;
  bit   no_idle;

  tsmb_in_if  in_ch();
  tsmb_out_if out_ch();

  texture_srt_matrix_builder #(.SINE_TABLE_BITS(TABLE_BITS)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  srt_checker #(.SINE_TABLE_BITS(TABLE_BITS)) chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic signed [31:0] pick_q16(int span);
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $signed($urandom_range(0, 2 * span * 65536)) - span * 65536;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.op = 1'($urandom_range(0, 1));
    it.srt_flags = 3'($urandom_range(0, 7));
    it.scale_u = pick_q16(2);
    it.scale_v = pick_q16(2);
    case ($urandom_range(0, 2))
      0: it.rot_degrees = $urandom;
      1: it.rot_degrees = $signed($urandom_range(0, 720 * 65536)) - 360 * 65536;
      default: it.rot_degrees = ($signed($urandom_range(0, 16)) - 8) * 90 * 65536;
    endcase
    it.trans_u = pick_q16(4);
    it.trans_v = pick_q16(4);
    return it;
  endfunction

  function automatic in_item_t mk(logic op, logic [2:0] fl, int su, int sv, int rd,
                                  int tu, int tv);
    in_item_t it;
    it.op = op; it.srt_flags = fl;
    it.scale_u = su; it.scale_v = sv; it.rot_degrees = rd;
    it.trans_u = tu; it.trans_v = tv;
    return it;
  endfunction

  // hold valid across back-to-back items; drop it only for a gap
  task automatic send(in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.item = it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int wait_cnt;
    in_ch.valid = 1'b0;
    in_ch.item = '0;
    hold_req = 1'b0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send(mk(1'b1, 3'b111, 0, 0, 0, 0, 0));
    send(mk(1'b0, 3'b000, 65536, 65536, 0, 0, 0));
    send(mk(1'b0, 3'b000, 2 * 65536, 3 * 65536, 90 * 65536, 32768, -16384));
    send(mk(1'b1, 3'b000, 65536, 65536, 180 * 65536, 65536, 65536));
    send(mk(1'b1, 3'b000, 65536, 65536, 270 * 65536, 0, 0));
    send(mk(1'b1, 3'b000, 65536, 65536, -90 * 65536, 0, 0));
    send(mk(1'b0, 3'b000, 65536, 65536, 720 * 65536, 0, 0));
    send(mk(1'b0, 3'b000, 65536, 65536, 46080, 0, 0));
    send(mk(1'b0, 3'b000, 65536, 65536, -46080, 0, 0));
    send(mk(1'b0, 3'b000, 65536, 65536, 32'h7fffffff, 0, 0));
    send(mk(1'b0, 3'b000, 65536, 65536, 32'h80000000, 0, 0));
    send(mk(1'b0, 3'b000, 32'h7fffffff, 32'h80000000, 45 * 65536,
            32'h7fffffff, 32'h80000000));
    send(mk(1'b1, 3'b000, 32'h80000000, 32'h7fffffff, 135 * 65536,
            32'h80000000, 32'h7fffffff));
    send(mk(1'b1, 3'b000, 32'h7fffffff, 32'h7fffffff, 0, 32'h7fffffff, 32'h7fffffff));
    send(mk(1'b1, 3'b001, 32'h12345678, 32'h9abcdef0, 30 * 65536, 65536, 65536));
    send(mk(1'b0, 3'b010, 2 * 65536, 65536, 33 * 65536, 65536, 2 * 65536));
    send(mk(1'b1, 3'b100, 65536, 2 * 65536, 60 * 65536, 32'h7fffffff, 5));
    send(mk(1'b0, 3'b011, 0, 0, 10 * 65536, 32'h80000000, 32'h7fffffff));
    send(mk(1'b1, 3'b110, -65536, 32768, 77 * 65536, 9, 9));
    send(mk(1'b0, 3'b101, 7, 7, -300 * 65536, 3, 3));
    send(mk(1'b1, 3'b111, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
            32'hffffffff));
    send(mk(1'b0, 3'b000, 0, 0, 0, 0, 0));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (n == 200) hold_req = 1'b1;
      if (n == 500) begin
        // stop offering until every result is out
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      send(rand_item());
    end
    in_ch.valid = 1'b0;
    no_idle = 1'b0;

    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 100000) begin
      @(negedge clk);
      wait_cnt++;
    end
    repeat (100) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
